/* design/nlt_pkg.sv */
// ---------------------------------------------------------------------------
// nlt_pkg: shared types and constants of the node liveness table
// Item and result layouts, command codes, register map and reset values.
// ---------------------------------------------------------------------------
`default_nettype none

package nlt_pkg;

  // command codes of the kind field
  localparam logic [1:0] KIND_OBSERVE = 2'd0;
  localparam logic [1:0] KIND_TICK    = 2'd1;
  localparam logic [1:0] KIND_QUERY   = 2'd2;

  // message classes of an observed packet
  localparam logic [1:0] CLASS_OTHER     = 2'd0;
  localparam logic [1:0] CLASS_HEARTBEAT = 2'd1;
  localparam logic [1:0] CLASS_FAULT     = 2'd2;

  // register map, index taken from paddr[2]
  localparam int unsigned APB_ADDR_W         = 3;
  localparam logic        REG_HB_INTERVAL    = 1'b0;
  localparam logic        REG_OFFLINE_TIMEOUT = 1'b1;

  localparam logic [31:0] HB_INTERVAL_RST     = 32'd1000;
  localparam logic [31:0] OFFLINE_TIMEOUT_RST = 32'd3000;

  localparam logic [15:0] FAULTS_MAX = 16'hFFFF;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] now_time;
    logic [7:0]  node_address;
    logic [1:0]  message_class;
    logic        tx_ready;
  } nlt_cmd_t;

  typedef struct packed {
    logic        heartbeat_sent;
    logic        found;
    logic        table_full;
    logic        node_online;
    logic [31:0] seen_time;
    logic [31:0] heartbeat_time;
    logic [15:0] faults;
    logic [4:0]  known_count;
  } nlt_res_t;

  typedef struct packed {
    logic [31:0] heartbeat_interval;
    logic [31:0] offline_timeout;
  } nlt_cfg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HBEAT,
    ST_WALK,
    ST_FINISH
  } nlt_state_e;

endpackage

`default_nettype wire

/* design/nlt_apb_regs.sv */
// ---------------------------------------------------------------------------
// nlt_apb_regs: configuration registers of the node liveness table
// APB-style slave, zero wait states, holding interval and timeout.
// ---------------------------------------------------------------------------
`default_nettype none

module nlt_apb_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [nlt_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [31:0]                   pwdata,
  output logic      [31:0]                   prdata,
  output logic                               pready,
  output nlt_pkg::nlt_cfg_t                  cfg_o
);

  nlt_pkg::nlt_cfg_t cfg_q;
  logic              wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.heartbeat_interval <= nlt_pkg::HB_INTERVAL_RST;
      cfg_q.offline_timeout    <= nlt_pkg::OFFLINE_TIMEOUT_RST;
    end else if (wr_en) begin
      case (paddr[2])
        nlt_pkg::REG_HB_INTERVAL:     cfg_q.heartbeat_interval <= pwdata;
        nlt_pkg::REG_OFFLINE_TIMEOUT: cfg_q.offline_timeout    <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      nlt_pkg::REG_HB_INTERVAL:     prdata = cfg_q.heartbeat_interval;
      nlt_pkg::REG_OFFLINE_TIMEOUT: prdata = cfg_q.offline_timeout;
      default:                      prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

/* design/node_liveness_table.sv */
// ---------------------------------------------------------------------------
// node_liveness_table: heartbeat liveness monitor for a table of nodes
// Sequencer walks the entry memory one slot a cycle through a shared
// wrapping subtract-and-compare unit.
// ---------------------------------------------------------------------------
// Usage:
//   Command channel: drive cmd_i and raise start while busy is low; the
//   item is taken at that edge and busy stays high until it is done.
//   Result channel: done_o pulses for one cycle with res_o; the receiver
//   cannot stall, so the result must be taken in that cycle.
//   Config: APB-style port, heartbeat_interval at 0x0, offline_timeout at
//   0x4, no wait states. Write only while busy is low.
// Flow: observe and query items walk every slot; a tick first passes
//   through the own-heartbeat check; an unused kind goes straight to the
//   finishing step. busy drops with done_o, so a new item can be
//   taken in the cycle its predecessor's result is shown.
//   The walk goes over the entry memory (one read and one write port),
//   one slot per cycle, followed by the registered read, a drain step,
//   the finishing step and the result register.
// Reset: table emptied (valid bits cleared, count zero), last send time
//   zero, registers back to 1000 and 3000; no clearing pass is needed.
// ---------------------------------------------------------------------------
`default_nettype none

module node_liveness_table #(
  parameter int unsigned NODE_SLOTS = 16,
  parameter int unsigned ADDR_BITS  = 8
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start,
  output logic                                busy,
  input  wire nlt_pkg::nlt_cmd_t              cmd_i,
  output logic                                done_o,
  output nlt_pkg::nlt_res_t                   res_o,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [nlt_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [31:0]                    pwdata,
  output logic      [31:0]                    prdata,
  output logic                                pready
);

  localparam int unsigned AW = (ADDR_BITS < 8) ? ADDR_BITS : 8;
  localparam int unsigned IW = (NODE_SLOTS > 1) ? $clog2(NODE_SLOTS) : 1;
  localparam int unsigned CW = $clog2(NODE_SLOTS + 1);

  typedef struct packed {
    logic [AW-1:0] addr;
    logic          online;
    logic [31:0]   seen;
    logic [31:0]   hb;
    logic [15:0]   faults;
  } entry_t;

  nlt_pkg::nlt_cfg_t cfg;

  nlt_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // control state
  nlt_pkg::nlt_state_e   state_q, state_d;
  logic [CW-1:0]         rd_cnt_q, rd_cnt_d;
  logic                  chk_pend_q, chk_pend_d;
  logic                  hit_q, hit_d;
  logic                  free_q, free_d;
  logic                  hb_sent_q, hb_sent_d;
  logic [NODE_SLOTS-1:0] valid_q, valid_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic [31:0]           last_tx_q, last_tx_d;
  logic                  done_q, done_d;
  // payload
  nlt_pkg::nlt_cmd_t     cmd_q, cmd_d;
  logic [IW-1:0]         chk_idx_q, chk_idx_d;
  logic [IW-1:0]         slot_q, slot_d;
  logic [IW-1:0]         free_idx_q, free_idx_d;
  entry_t                ent_q, ent_d;
  nlt_pkg::nlt_res_t     res_q, res_d;

  // entry memory, one write and one registered read per cycle
  entry_t                mem [NODE_SLOTS];
  entry_t                rdata_q;
  logic                  mem_re, mem_we;
  logic [IW-1:0]         mem_raddr, mem_waddr;
  entry_t                mem_wdata;

  // shared wrapping subtract-and-compare unit
  logic [31:0]           cmp_opnd, cmp_lim, cmp_diff;
  logic                  cmp_ge;

  logic [AW-1:0]         key;
  logic                  chk_valid;
  logic [IW-1:0]         upd_slot;
  entry_t                upd;
  logic [8:0]            cnt_ext;

  assign key       = cmd_q.node_address[AW-1:0];
  assign chk_valid = valid_q[chk_idx_q];

  assign cmp_opnd = (state_q == nlt_pkg::ST_HBEAT) ? last_tx_q : rdata_q.seen;
  assign cmp_lim  = (state_q == nlt_pkg::ST_HBEAT) ? cfg.heartbeat_interval
                                                   : cfg.offline_timeout;
  assign cmp_diff = cmd_q.now_time - cmp_opnd;
  assign cmp_ge   = (cmp_diff >= cmp_lim);

  assign busy   = (state_q != nlt_pkg::ST_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

  always_comb begin
    state_d    = state_q;
    rd_cnt_d   = rd_cnt_q;
    chk_pend_d = 1'b0;
    chk_idx_d  = chk_idx_q;
    hit_d      = hit_q;
    free_d     = free_q;
    hb_sent_d  = hb_sent_q;
    valid_d    = valid_q;
    cnt_d      = cnt_q;
    last_tx_d  = last_tx_q;
    done_d     = 1'b0;
    cmd_d      = cmd_q;
    slot_d     = slot_q;
    free_idx_d = free_idx_q;
    ent_d      = ent_q;
    res_d      = res_q;
    mem_re     = 1'b0;
    mem_raddr  = rd_cnt_q[IW-1:0];
    mem_we     = 1'b0;
    mem_waddr  = chk_idx_q;
    mem_wdata  = rdata_q;
    upd_slot   = hit_q ? slot_q : free_idx_q;
    upd        = ent_q;
    cnt_ext    = 9'd0;

    case (state_q)
      nlt_pkg::ST_IDLE: begin
        if (start) begin
          cmd_d     = cmd_i;
          rd_cnt_d  = '0;
          hit_d     = 1'b0;
          free_d    = 1'b0;
          hb_sent_d = 1'b0;
          case (cmd_i.kind)
            nlt_pkg::KIND_OBSERVE: state_d = nlt_pkg::ST_WALK;
            nlt_pkg::KIND_QUERY:   state_d = nlt_pkg::ST_WALK;
            nlt_pkg::KIND_TICK:    state_d = nlt_pkg::ST_HBEAT;
            default:               state_d = nlt_pkg::ST_FINISH;
          endcase
        end
      end

      nlt_pkg::ST_HBEAT: begin
        if (cmp_ge && cmd_q.tx_ready) begin
          last_tx_d = cmd_q.now_time;
          hb_sent_d = 1'b1;
        end
        state_d = nlt_pkg::ST_WALK;
      end

      nlt_pkg::ST_WALK: begin
        // read slot rd_cnt while checking the slot read in the previous cycle
        if (rd_cnt_q < CW'(NODE_SLOTS)) begin
          mem_re     = 1'b1;
          chk_pend_d = 1'b1;
          chk_idx_d  = rd_cnt_q[IW-1:0];
          rd_cnt_d   = rd_cnt_q + CW'(1);
        end else if (!chk_pend_q) begin
          state_d = nlt_pkg::ST_FINISH;
        end
        if (chk_pend_q) begin
          if (cmd_q.kind == nlt_pkg::KIND_TICK) begin
            if (chk_valid && rdata_q.online && cmp_ge) begin
              mem_we           = 1'b1;
              mem_wdata        = rdata_q;
              mem_wdata.online = 1'b0;
            end
          end else begin
            if (chk_valid && (rdata_q.addr == key) && !hit_q) begin
              hit_d  = 1'b1;
              slot_d = chk_idx_q;
              ent_d  = rdata_q;
            end
            if (!chk_valid && !free_q) begin
              free_d     = 1'b1;
              free_idx_d = chk_idx_q;
            end
          end
        end
      end

      nlt_pkg::ST_FINISH: begin
        res_d   = '0;
        done_d  = 1'b1;
        state_d = nlt_pkg::ST_IDLE;
        case (cmd_q.kind)
          nlt_pkg::KIND_OBSERVE: begin
            if (hit_q || free_q) begin
              if (!hit_q) begin
                // fresh entry starts from the reset values
                upd.addr   = key;
                upd.hb     = 32'd0;
                upd.faults = 16'd0;
                cnt_d      = cnt_q + CW'(1);
              end
              upd.online = 1'b1;
              upd.seen   = cmd_q.now_time;
              if (cmd_q.message_class == nlt_pkg::CLASS_HEARTBEAT) begin
                upd.hb = cmd_q.now_time;
              end else if (cmd_q.message_class == nlt_pkg::CLASS_FAULT &&
                           upd.faults != nlt_pkg::FAULTS_MAX) begin
                upd.faults = upd.faults + 16'd1;
              end
              mem_we            = 1'b1;
              mem_waddr         = upd_slot;
              mem_wdata         = upd;
              valid_d[upd_slot] = 1'b1;
              res_d.found          = 1'b1;
              res_d.node_online    = 1'b1;
              res_d.seen_time      = upd.seen;
              res_d.heartbeat_time = upd.hb;
              res_d.faults         = upd.faults;
            end else begin
              res_d.table_full = 1'b1;
            end
          end
          nlt_pkg::KIND_QUERY: begin
            if (hit_q) begin
              res_d.found          = 1'b1;
              res_d.node_online    = ent_q.online;
              res_d.seen_time      = ent_q.seen;
              res_d.heartbeat_time = ent_q.hb;
              res_d.faults         = ent_q.faults;
            end
          end
          nlt_pkg::KIND_TICK: begin
            res_d.heartbeat_sent = hb_sent_q;
          end
          default: ;
        endcase
        cnt_ext           = 9'(cnt_d);
        res_d.known_count = (cnt_ext > 9'd31) ? 5'd31 : cnt_ext[4:0];
      end

      default: state_d = nlt_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= nlt_pkg::ST_IDLE;
      rd_cnt_q   <= '0;
      chk_pend_q <= 1'b0;
      hit_q      <= 1'b0;
      free_q     <= 1'b0;
      hb_sent_q  <= 1'b0;
      valid_q    <= '0;
      cnt_q      <= '0;
      last_tx_q  <= 32'd0;
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      rd_cnt_q   <= rd_cnt_d;
      chk_pend_q <= chk_pend_d;
      hit_q      <= hit_d;
      free_q     <= free_d;
      hb_sent_q  <= hb_sent_d;
      valid_q    <= valid_d;
      cnt_q      <= cnt_d;
      last_tx_q  <= last_tx_d;
      done_q     <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    chk_idx_q  <= chk_idx_d;
    slot_q     <= slot_d;
    free_idx_q <= free_idx_d;
    ent_q      <= ent_d;
    res_q      <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

`ifndef SYNTHESIS
  a_done_after_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == nlt_pkg::ST_FINISH))
    else $error("result strobe without a finishing step");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted item did not make the block busy");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(NODE_SLOTS))
    else $error("entry count above table size");

  a_full_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.table_full) |-> (cnt_q == CW'(NODE_SLOTS) && (&valid_q)))
    else $error("packet dropped while a slot was free");

  a_count_tracks_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == nlt_pkg::ST_IDLE) |-> ($countones(valid_q) == int'(cnt_q)))
    else $error("fill count out of step with valid bits");
`endif

endmodule

`default_nettype wire

/* dv/testbench.sv */
// ---------------------------------------------------------------------------
// testbench: self-checking bench for node_liveness_table
// Items go in over the start/busy command port from a backlog queue; every
// accepted item runs through a local copy of the node table to predict its
// status word, which the monitor checks field by field against done_o/res_o.
// Register settings change between phases over the APB port, with read-back.
// ---------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          SLOTS       = 16;
  localparam logic [1:0]  KIND_UNUSED = 2'd3;
  localparam logic [1:0]  CLASS_SPARE = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 200_000;
  localparam int          MAX_SHOWN   = 40;
  localparam int          PHASES      = 6;
  localparam int          PHASE_ITEMS = 130;
  // back-to-back fault packets on one node
  localparam int          FAULT_RUN   = 10;

  logic                           clk_i   = 1'b0;
  logic                           rst_ni  = 1'b0;
  logic                           start   = 1'b0;
  logic                           busy;
  nlt_pkg::nlt_cmd_t              cmd_i   = '0;
  logic                           done_o;
  nlt_pkg::nlt_res_t              res_o;
  logic                           psel    = 1'b0;
  logic                           penable = 1'b0;
  logic                           pwrite  = 1'b0;
  logic [nlt_pkg::APB_ADDR_W-1:0] paddr   = '0;
  logic [31:0]                    pwdata  = '0;
  logic [31:0]                    prdata;
  logic                           pready;

  node_liveness_table DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .cmd_i   (cmd_i),
    .done_o  (done_o),
    .res_o   (res_o),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #10 clk_i = ~clk_i;

  // local copy of the node table
  logic        tbl_valid  [SLOTS];
  logic [7:0]  tbl_addr   [SLOTS];
  logic        tbl_online [SLOTS];
  logic [31:0] tbl_seen   [SLOTS];
  logic [31:0] tbl_hb     [SLOTS];
  logic [15:0] tbl_faults [SLOTS];
  logic [31:0] last_send;
  logic [31:0] cfg_interval;
  logic [31:0] cfg_timeout;

  nlt_pkg::nlt_cmd_t cmd_backlog_q[$];
  nlt_pkg::nlt_res_t status_due_q[$];
  nlt_pkg::nlt_res_t want;
  logic        taken;
  int          gap_left    = 0;
  int          idle_pct    = 0;
  int          mismatches  = 0;
  int          n_results   = 0;
  int          n_hb_sent   = 0;
  int          n_dropped   = 0;
  int          kind_seen[4];
  int unsigned cycle_count = 0;
  logic [31:0] ms_clock    = 32'd5000;

  logic [7:0]  addr_pool[12] = '{8'h00, 8'hFF, 8'h5A, 8'hA5, 8'h0F, 8'hF0,
                                 8'h33, 8'hCC, 8'h01, 8'h80, 8'h7E, 8'h81};

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      tbl_valid[i]  = 1'b0;
      tbl_addr[i]   = '0;
      tbl_online[i] = 1'b0;
      tbl_seen[i]   = '0;
      tbl_hb[i]     = '0;
      tbl_faults[i] = '0;
    end
    for (int k = 0; k < 4; k++) kind_seen[k] = 0;
    last_send    = '0;
    cfg_interval = nlt_pkg::HB_INTERVAL_RST;
    cfg_timeout  = nlt_pkg::OFFLINE_TIMEOUT_RST;
  end

  function automatic int find_slot(input logic [7:0] a);
    int s;
    s = -1;
    for (int i = 0; i < SLOTS; i++)
      if (s < 0 && tbl_valid[i] && tbl_addr[i] == a) s = i;
    return s;
  endfunction

  // applies one item to the local table and returns its status word
  function automatic nlt_pkg::nlt_res_t table_update(input nlt_pkg::nlt_cmd_t c);
    nlt_pkg::nlt_res_t r;
    int                slot;
    int                n;
    logic [31:0]       since;
    r    = '0;
    slot = -1;
    case (c.kind)
      nlt_pkg::KIND_OBSERVE: begin
        slot = find_slot(c.node_address);
        if (slot < 0) begin
          for (int i = 0; i < SLOTS; i++)
            if (slot < 0 && !tbl_valid[i]) begin
              tbl_valid[i] = 1'b1;
              tbl_addr[i]  = c.node_address;
              slot = i;
            end
        end
        if (slot < 0) begin
          r.table_full = 1'b1;
        end else begin
          tbl_online[slot] = 1'b1;
          tbl_seen[slot]   = c.now_time;
          if (c.message_class == nlt_pkg::CLASS_HEARTBEAT) begin
            tbl_hb[slot] = c.now_time;
          end else if (c.message_class == nlt_pkg::CLASS_FAULT &&
                       tbl_faults[slot] != nlt_pkg::FAULTS_MAX) begin
            tbl_faults[slot] = tbl_faults[slot] + 16'd1;
          end
        end
      end
      nlt_pkg::KIND_TICK: begin
        since = c.now_time - last_send;
        if (since >= cfg_interval && c.tx_ready) begin
          last_send = c.now_time;
          r.heartbeat_sent = 1'b1;
        end
        for (int i = 0; i < SLOTS; i++) begin
          since = c.now_time - tbl_seen[i];
          if (tbl_valid[i] && tbl_online[i] && since >= cfg_timeout) tbl_online[i] = 1'b0;
        end
      end
      nlt_pkg::KIND_QUERY: slot = find_slot(c.node_address);
      default: ;
    endcase
    if (slot >= 0) begin
      r.found          = 1'b1;
      r.node_online    = tbl_online[slot];
      r.seen_time      = tbl_seen[slot];
      r.heartbeat_time = tbl_hb[slot];
      r.faults         = tbl_faults[slot];
    end
    n = 0;
    for (int i = 0; i < SLOTS; i++) if (tbl_valid[i]) n++;
    r.known_count = (n > 31) ? 5'd31 : 5'(n);
    return r;
  endfunction

  task automatic compare_field(input string fname, input logic [31:0] want_v,
                               input logic [31:0] got_v);
    if (got_v !== want_v) begin
      mismatches++;
      if (mismatches <= MAX_SHOWN)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want_v, got_v);
    end
  endtask

  // driver: one item per start/!busy edge, random idle bursts in between
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      taken = start && !busy;
      if (taken) begin
        status_due_q.push_back(table_update(cmd_i));
        kind_seen[cmd_i.kind]++;
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) gap_left = $urandom_range(1, 6);
      end
      if (start && !taken) begin
        // item held until busy drops
      end else if (gap_left > 0) begin
        start <= 1'b0;
        if (!busy && !taken) gap_left--;
      end else if (cmd_backlog_q.size() > 0) begin
        cmd_i <= cmd_backlog_q.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: results cannot be held off, so every done_o cycle is checked
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      n_results++;
      if (status_due_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("%0t: result with nothing outstanding, expected none, actual %p",
                   $time, res_o);
      end else begin
        want = status_due_q.pop_front();
        compare_field("heartbeat_sent", 32'(want.heartbeat_sent),
                      32'(res_o.heartbeat_sent));
        compare_field("found", 32'(want.found), 32'(res_o.found));
        compare_field("table_full", 32'(want.table_full), 32'(res_o.table_full));
        compare_field("node_online", 32'(want.node_online), 32'(res_o.node_online));
        compare_field("seen_time", want.seen_time, res_o.seen_time);
        compare_field("heartbeat_time", want.heartbeat_time, res_o.heartbeat_time);
        compare_field("faults", 32'(want.faults), 32'(res_o.faults));
        compare_field("known_count", 32'(want.known_count), 32'(res_o.known_count));
        if (want.heartbeat_sent) n_hb_sent++;
        if (want.table_full) n_dropped++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: cycle limit reached, %0d results still outstanding",
               $time, status_due_q.size());
      $display("testbench NOT OK");
      $finish;
    end
  end

  task automatic apb_xfer(input logic wr, input logic idx, input logic [31:0] wdata,
                          output logic [31:0] rdata);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (pready !== 1'b1) @(posedge clk_i);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_register(input logic idx, input logic [31:0] value);
    logic [31:0] rd;
    apb_xfer(1'b1, idx, value, rd);
    if (idx == nlt_pkg::REG_HB_INTERVAL) cfg_interval = value;
    else cfg_timeout = value;
    apb_xfer(1'b0, idx, '0, rd);
    compare_field("register read-back", value, rd);
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    while (cmd_backlog_q.size() != 0 || start || status_due_q.size() != 0 || busy)
      @(negedge clk_i);
  endtask

  function automatic nlt_pkg::nlt_cmd_t mk_cmd(input logic [1:0] k, input logic [31:0] t,
                                               input logic [7:0] a, input logic [1:0] cl,
                                               input logic rdy);
    nlt_pkg::nlt_cmd_t c;
    c.kind          = k;
    c.now_time      = t;
    c.node_address  = a;
    c.message_class = cl;
    c.tx_ready      = rdy;
    return c;
  endfunction

  // wide_pct: share of addresses drawn from the full range instead of the pool
  task automatic random_items(input int count, input int wide_pct);
    nlt_pkg::nlt_cmd_t c;
    int                roll;
    repeat (count) begin
      roll = $urandom_range(0, 99);
      c.kind = (roll < 45) ? nlt_pkg::KIND_OBSERVE : (roll < 75) ? nlt_pkg::KIND_TICK :
               (roll < 95) ? nlt_pkg::KIND_QUERY : KIND_UNUSED;
      roll = $urandom_range(0, 99);
      if (roll < 3) ms_clock = $urandom;
      else if (roll < 8) ms_clock += $urandom_range(0, 20000);
      else ms_clock += $urandom_range(0, 400);
      c.now_time = ms_clock;
      if ($urandom_range(0, 99) < wide_pct) c.node_address = 8'($urandom_range(0, 255));
      else c.node_address = addr_pool[$urandom_range(0, 11)];
      c.message_class = 2'($urandom_range(0, 3));
      c.tx_ready      = ($urandom_range(0, 3) != 0);
      cmd_backlog_q.push_back(c);
    end
  endtask

  initial begin
    logic [31:0] ph_int [PHASES];
    logic [31:0] ph_tmo [PHASES];
    int          ph_wide[PHASES];
    int          ph_idle[PHASES];
    ph_int[0] = 32'd0;          ph_tmo[0] = 32'd0;          ph_wide[0] = 0;  ph_idle[0] = 30;
    ph_int[1] = 32'hFFFF_FFFF;  ph_tmo[1] = 32'hFFFF_FFFF;  ph_wide[1] = 0;  ph_idle[1] = 20;
    ph_int[2] = nlt_pkg::HB_INTERVAL_RST; ph_tmo[2] = nlt_pkg::OFFLINE_TIMEOUT_RST;
    ph_wide[2] = 30; ph_idle[2] = 40;
    ph_int[3] = $urandom_range(0, 800); ph_tmo[3] = $urandom_range(0, 4000);
    ph_wide[3] = 30; ph_idle[3] = 25;
    ph_int[4] = 32'd1;          ph_tmo[4] = 32'hFFFF_FFFF;  ph_wide[4] = 50; ph_idle[4] = 30;
    ph_int[5] = 32'hFFFF_FFFF;  ph_tmo[5] = 32'd0;          ph_wide[5] = 20; ph_idle[5] = 15;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed pass at reset register values
    @(negedge clk_i);
    idle_pct = 20;
    cmd_backlog_q.push_back(mk_cmd(nlt_pkg::KIND_QUERY, 32'd0, 8'h00,
                                   nlt_pkg::CLASS_OTHER, 1'b0));
    cmd_backlog_q.push_back(mk_cmd(nlt_pkg::KIND_OBSERVE, 32'd0, 8'h00,
                                   nlt_pkg::CLASS_OTHER, 1'b1));
    cmd_backlog_q.push_back(mk_cmd(nlt_pkg::KIND_OBSERVE, 32'd5, 8'hFF,
                                   nlt_pkg::CLASS_HEARTBEAT, 1'b0));
    cmd_backlog_q.push_back(mk_cmd(nlt_pkg::KIND_OBSERVE, 32'd10, 8'h00,
                                   nlt_pkg::CLASS_FAULT, 1'b1));
    cmd_backlog_q.push_back(mk_cmd(nlt_pkg::KIND_OBSERVE, 32'd20, 8'h5A,
                                   CLASS_SPARE, 1'b0));
    cmd_backlog_q.push_back(mk_cmd(nlt_pkg::KIND_OBSERVE, 32'd25, 8'h00,
                                   nlt_pkg::CLASS_FAULT, 1'b0));
    cmd_backlog_q.push_back(mk_cmd(nlt_pkg::KIND_QUERY, 32'd30, 8'hFF,
                                   nlt_pkg::CLASS_FAULT, 1'b1));
    cmd_backlog_q.push_back(mk_cmd(nlt_pkg::KIND_QUERY, 32'd30, 8'hA5,
                                   nlt_pkg::CLASS_OTHER, 1'b0));
    // interval not yet elapsed, then elapsed but transmitter busy, then sent
    cmd_backlog_q.push_back(mk_cmd(nlt_pkg::KIND_TICK, 32'd999, 8'h00,
                                   nlt_pkg::CLASS_OTHER, 1'b1));
    cmd_backlog_q.push_back(mk_cmd(nlt_pkg::KIND_TICK, 32'd1000, 8'h00,
                                   nlt_pkg::CLASS_OTHER, 1'b0));
    cmd_backlog_q.push_back(mk_cmd(nlt_pkg::KIND_TICK, 32'd1000, 8'h00,
                                   nlt_pkg::CLASS_OTHER, 1'b1));
    // silence of exactly the timeout for 0xFF only
    cmd_backlog_q.push_back(mk_cmd(nlt_pkg::KIND_TICK, 32'd3005, 8'hFF,
                                   nlt_pkg::CLASS_HEARTBEAT, 1'b1));
    cmd_backlog_q.push_back(mk_cmd(nlt_pkg::KIND_QUERY, 32'd3006, 8'hFF,
                                   nlt_pkg::CLASS_OTHER, 1'b0));
    cmd_backlog_q.push_back(mk_cmd(KIND_UNUSED, 32'hFFFF_FFFF, 8'hFF, CLASS_SPARE, 1'b1));
    cmd_backlog_q.push_back(mk_cmd(nlt_pkg::KIND_OBSERVE, 32'hFFFF_FFFF, 8'hFF,
                                   nlt_pkg::CLASS_HEARTBEAT, 1'b1));
    // time wraps past zero: short silence, node stays online
    cmd_backlog_q.push_back(mk_cmd(nlt_pkg::KIND_TICK, 32'h0000_0010, 8'hFF,
                                   nlt_pkg::CLASS_FAULT, 1'b1));
    cmd_backlog_q.push_back(mk_cmd(nlt_pkg::KIND_QUERY, 32'h0000_0011, 8'hFF,
                                   nlt_pkg::CLASS_OTHER, 1'b1));
    cmd_backlog_q.push_back(mk_cmd(nlt_pkg::KIND_TICK, 32'h0000_2000, 8'h00,
                                   nlt_pkg::CLASS_OTHER, 1'b1));
    cmd_backlog_q.push_back(mk_cmd(nlt_pkg::KIND_QUERY, 32'h0000_2001, 8'h00,
                                   nlt_pkg::CLASS_OTHER, 1'b0));
    cmd_backlog_q.push_back(mk_cmd(nlt_pkg::KIND_QUERY, 32'h0000_2002, 8'h5A,
                                   nlt_pkg::CLASS_OTHER, 1'b1));
    ms_clock = 32'h0000_3000;
    wait_idle();

    for (int ph = 0; ph < PHASES; ph++) begin
      set_register(nlt_pkg::REG_HB_INTERVAL, ph_int[ph]);
      set_register(nlt_pkg::REG_OFFLINE_TIMEOUT, ph_tmo[ph]);
      if (ph == 2) ms_clock = 32'hFFFF_F000;
      @(negedge clk_i);
      idle_pct = ph_idle[ph];
      random_items(PHASE_ITEMS, ph_wide[ph]);
      wait_idle();
    end

    // closing part without idling: a run of fault packets on node 0x00
    set_register(nlt_pkg::REG_HB_INTERVAL, $urandom_range(0, 2000));
    set_register(nlt_pkg::REG_OFFLINE_TIMEOUT, $urandom_range(0, 6000));
    @(negedge clk_i);
    idle_pct = 0;
    for (int i = 0; i < FAULT_RUN; i++) begin
      ms_clock += 32'd1;
      cmd_backlog_q.push_back(mk_cmd(nlt_pkg::KIND_OBSERVE, ms_clock, 8'h00,
                                     nlt_pkg::CLASS_FAULT, 1'(i)));
    end
    random_items(40, 30);
    wait_idle();
    repeat (SLOTS + 8) @(posedge clk_i);

    $display("covered %0d observe, %0d tick, %0d query and %0d unused-kind items",
             kind_seen[nlt_pkg::KIND_OBSERVE], kind_seen[nlt_pkg::KIND_TICK],
             kind_seen[nlt_pkg::KIND_QUERY], kind_seen[KIND_UNUSED]);
    $display("%0d results checked over %0d register settings: %0d heartbeats, %0d drops",
             n_results, PHASES + 2, n_hb_sent, n_dropped);
    if (mismatches == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
